// ===== hdl/velocity_pi_with_filtered_setpoint_macros.svh =====
// Assertion macros for the RTL of the velocity regulator.
`ifndef VELOCITY_PI_WITH_FILTERED_SETPOINT_MACROS_SVH
`define VELOCITY_PI_WITH_FILTERED_SETPOINT_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked on every rising edge outside reset.
`define VPI_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication, checked on every rising edge outside reset.
`define VPI_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`else
`define VPI_ASSERT_IMP(lbl, ante, cons, msg)
`define VPI_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

// ===== hdl/vpi_pkg.sv =====
package vpi_pkg;

  // Fixed field widths.
  localparam int DATA_W    = 32;
  localparam int ERR_W     = 33;
  localparam int GAIN_W    = 27;
  localparam int COEFF_W   = 17;
  localparam int COEFF_BITS = 16;
  localparam int CFG_IDX_W = 3;

  // Shared multiplier and accumulator widths.
  localparam int MUL_A_W = 34;
  localparam int MUL_B_W = 28;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;
  localparam int ACC_W   = 64;

  // Default number of fractional bits.
  localparam int FRAC_BITS_DEF = 16;

  // Request codes.
  localparam logic [1:0] REQ_TICK  = 2'd0;
  localparam logic [1:0] REQ_SET   = 2'd1;
  localparam logic [1:0] REQ_START = 2'd2;
  localparam logic [1:0] REQ_STOP  = 2'd3;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_DAMPING  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INT_GAIN = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INT_MAX  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_INT_MIN  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_COEFF    = 3'd4;

  // Coefficient value that means "take the new target as is".
  localparam logic [COEFF_W-1:0] COEFF_ONE = 17'h10000;

  // Sequencer states, one-hot.
  typedef enum logic [9:0] {
    ST_IDLE   = 10'b00_0000_0001,
    ST_MUL_TV = 10'b00_0000_0010,
    ST_MUL_FT = 10'b00_0000_0100,
    ST_MUL_DG = 10'b00_0000_1000,
    ST_MUL_FD = 10'b00_0001_0000,
    ST_ERR    = 10'b00_0010_0000,
    ST_INTEG  = 10'b00_0100_0000,
    ST_MUL_E  = 10'b00_1000_0000,
    ST_MUL_I  = 10'b01_0000_0000,
    ST_OUT    = 10'b10_0000_0000
  } state_t;

  // Whole-number gain in fixed point, saturated to the gain register.
  function automatic logic [GAIN_W-1:0] gain_default(input int unsigned whole,
                                                     input int unsigned frac);
    logic [63:0] v;
    v = 64'(whole) << frac;
    if (v > 64'((1 << GAIN_W) - 1)) begin
      gain_default = {GAIN_W{1'b1}};
    end else begin
      gain_default = v[GAIN_W-1:0];
    end
  endfunction

endpackage

// ===== hdl/velocity_pi_with_filtered_setpoint.sv =====
// A tick steps through the multiply, error, integrator and output states of the
// sequencer, using the single shared multiplier that forms six products per tick;
// a new request is taken only once the previous tick has left the output state.
// Reset (synchronous, active high) loads the default gains and clamp bounds and
// clears target, filtered target, integrator and the finished flag.
`include "velocity_pi_with_filtered_setpoint_macros.svh"

module velocity_pi_with_filtered_setpoint #(
  parameter int FRAC_BITS = vpi_pkg::FRAC_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  // Configuration write channel.
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [vpi_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [vpi_pkg::DATA_W-1:0]            cfg_data,
  // Request channel.
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic [1:0]                            req_type,
  input  logic signed [vpi_pkg::DATA_W-1:0]     value,
  // Result channel.
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [vpi_pkg::DATA_W-1:0]     torque,
  output logic                                  halted
);

  localparam int DW = vpi_pkg::DATA_W;
  localparam int GW = vpi_pkg::GAIN_W;
  localparam int CW = vpi_pkg::COEFF_W;
  localparam int AW = vpi_pkg::MUL_A_W;
  localparam int BW = vpi_pkg::MUL_B_W;
  localparam int PW = vpi_pkg::PROD_W;
  localparam int XW = vpi_pkg::ACC_W;
  localparam int EW = vpi_pkg::ERR_W;
  localparam int CB = vpi_pkg::COEFF_BITS;

  localparam logic [GW-1:0] DAMP_RST = vpi_pkg::gain_default(50, FRAC_BITS);
  localparam logic [GW-1:0] KI_RST   = vpi_pkg::gain_default(5, FRAC_BITS);
  localparam logic signed [DW-1:0] HALF_RST = DW'(64'd1 << (FRAC_BITS - 1));
  localparam logic signed [XW-1:0] ROUND_C  = XW'(64'd1 << (CB - 1));
  localparam logic signed [XW-1:0] ROUND_F  = XW'(64'd1 << (FRAC_BITS - 1));

  // Configuration registers.
  logic [GW-1:0]         damp_gain;
  logic [GW-1:0]         int_gain;
  logic signed [DW-1:0]  int_max;
  logic signed [DW-1:0]  int_min;
  logic [CW-1:0]         coeff;

  // Controller state.
  logic signed [DW-1:0]  target;
  logic signed [DW-1:0]  ft;
  logic [GW-1:0]         fd;
  logic signed [DW-1:0]  integ;
  logic                  finished;

  // Per-tick working registers.
  vpi_pkg::state_t       state;
  vpi_pkg::state_t       state_next;
  logic signed [DW-1:0]  meas;
  logic signed [EW-1:0]  err;
  logic signed [XW-1:0]  acc;

  // Shared multiply-accumulate unit.
  logic [CW-1:0]         c_eff;
  logic [CW-1:0]         c_rest;
  logic signed [AW-1:0]  mul_a;
  logic signed [BW-1:0]  mul_b;
  logic signed [PW-1:0]  prod;
  logic signed [XW-1:0]  mac_base;
  logic signed [XW-1:0]  mac;

  // Integrator update and output saturation.
  logic signed [DW+1:0]  integ_sum;
  logic signed [DW-1:0]  integ_clamped;
  logic signed [XW-1:0]  tq_shift;
  logic signed [DW-1:0]  tq_sat;

  logic in_xfer;
  logic out_load;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == vpi_pkg::ST_IDLE);
  assign in_xfer   = in_valid && in_ready;
  assign out_load  = (state == vpi_pkg::ST_OUT) && (!out_valid || out_ready);

  // Coefficients above one act as one.
  assign c_eff  = (coeff > vpi_pkg::COEFF_ONE) ? vpi_pkg::COEFF_ONE : coeff;
  assign c_rest = vpi_pkg::COEFF_ONE - c_eff;

  // Operand selection for the shared multiplier.
  always_comb begin
    mul_a    = '0;
    mul_b    = '0;
    mac_base = acc;
    unique case (state)
      vpi_pkg::ST_MUL_TV: begin
        mul_a    = AW'(target);
        mul_b    = BW'(c_eff);
        mac_base = ROUND_C;
      end
      vpi_pkg::ST_MUL_FT: begin
        mul_a = AW'(ft);
        mul_b = BW'(c_rest);
      end
      vpi_pkg::ST_MUL_DG: begin
        mul_a    = AW'(damp_gain);
        mul_b    = BW'(c_eff);
        mac_base = ROUND_C;
      end
      vpi_pkg::ST_MUL_FD: begin
        mul_a = AW'(fd);
        mul_b = BW'(c_rest);
      end
      vpi_pkg::ST_MUL_E: begin
        mul_a    = AW'(err);
        mul_b    = BW'(fd);
        mac_base = ROUND_F;
      end
      vpi_pkg::ST_MUL_I: begin
        mul_a = AW'(integ);
        mul_b = BW'(int_gain);
      end
      default: begin
        mul_a = '0;
      end
    endcase
  end

  assign prod = mul_a * mul_b;
  assign mac  = mac_base + XW'(prod);

  // Integrator: add the error, apply the lower bound, then the upper bound.
  always_comb begin
    integ_sum = (DW+2)'(integ) + (DW+2)'(err);
    if (integ_sum < (DW+2)'(int_min)) begin
      integ_sum = (DW+2)'(int_min);
    end
    if (integ_sum > (DW+2)'(int_max)) begin
      integ_sum = (DW+2)'(int_max);
    end
    integ_clamped = integ_sum[DW-1:0];
  end

  // Torque: rounded shift, then saturation to 32 bits.
  always_comb begin
    tq_shift = acc >>> FRAC_BITS;
    if ((&tq_shift[XW-1:DW-1]) || !(|tq_shift[XW-1:DW-1])) begin
      tq_sat = tq_shift[DW-1:0];
    end else if (tq_shift[XW-1]) begin
      tq_sat = {1'b1, {(DW-1){1'b0}}};
    end else begin
      tq_sat = {1'b0, {(DW-1){1'b1}}};
    end
  end

  // Sequencer next state.
  always_comb begin
    state_next = state;
    unique case (state)
      vpi_pkg::ST_IDLE: begin
        if (in_xfer && (req_type == vpi_pkg::REQ_TICK)) begin
          state_next = vpi_pkg::ST_MUL_TV;
        end
      end
      vpi_pkg::ST_MUL_TV: state_next = vpi_pkg::ST_MUL_FT;
      vpi_pkg::ST_MUL_FT: state_next = vpi_pkg::ST_MUL_DG;
      vpi_pkg::ST_MUL_DG: state_next = vpi_pkg::ST_MUL_FD;
      vpi_pkg::ST_MUL_FD: state_next = vpi_pkg::ST_ERR;
      vpi_pkg::ST_ERR:    state_next = vpi_pkg::ST_INTEG;
      vpi_pkg::ST_INTEG:  state_next = vpi_pkg::ST_MUL_E;
      vpi_pkg::ST_MUL_E:  state_next = vpi_pkg::ST_MUL_I;
      vpi_pkg::ST_MUL_I:  state_next = vpi_pkg::ST_OUT;
      vpi_pkg::ST_OUT: begin
        if (out_load) begin
          state_next = vpi_pkg::ST_IDLE;
        end
      end
      default: state_next = vpi_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= vpi_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Configuration register writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      damp_gain <= DAMP_RST;
      int_gain  <= KI_RST;
      int_max   <= HALF_RST;
      int_min   <= -HALF_RST;
      coeff     <= vpi_pkg::COEFF_ONE;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        vpi_pkg::REG_DAMPING:  damp_gain <= cfg_data[GW-1:0];
        vpi_pkg::REG_INT_GAIN: int_gain  <= cfg_data[GW-1:0];
        vpi_pkg::REG_INT_MAX:  int_max   <= cfg_data;
        vpi_pkg::REG_INT_MIN:  int_min   <= cfg_data;
        vpi_pkg::REG_COEFF:    coeff     <= cfg_data[CW-1:0];
        default: ;
      endcase
    end
  end

  // Controller state: request handling and tick updates.
  always_ff @(posedge clk) begin
    if (rst) begin
      target   <= '0;
      ft       <= '0;
      fd       <= DAMP_RST;
      integ    <= '0;
      finished <= 1'b0;
    end else begin
      if (in_xfer) begin
        unique case (req_type)
          vpi_pkg::REQ_SET: target <= value;
          vpi_pkg::REQ_START: begin
            target   <= '0;
            ft       <= '0;
            finished <= 1'b0;
          end
          vpi_pkg::REQ_STOP: finished <= 1'b1;
          default: ;
        endcase
      end
      if (state == vpi_pkg::ST_MUL_DG) begin
        ft <= acc[CB +: DW];
      end
      if (state == vpi_pkg::ST_ERR) begin
        fd <= acc[CB +: GW];
      end
      if (state == vpi_pkg::ST_INTEG) begin
        integ <= integ_clamped;
      end
    end
  end

  // Working registers of the tick datapath.
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      meas <= value;
    end
    if (state == vpi_pkg::ST_ERR) begin
      err <= EW'(ft) - EW'(meas);
    end
    acc <= mac;
  end

  // Output register: holds the result until it is transferred.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      torque <= tq_sat;
      halted <= finished;
    end
  end

  // A new result appears only from the output step of the sequencer.
  `VPI_ASSERT_IMP(a_out_src, $rose(out_valid), $past(state) == vpi_pkg::ST_OUT, "result without output step")
  // An accepted tick starts the multiply sequence.
  `VPI_ASSERT_NXT(a_tick_start, in_xfer && (req_type == vpi_pkg::REQ_TICK), state == vpi_pkg::ST_MUL_TV, "tick did not start sequence")
  // The updated integrator never exceeds the upper bound.
  `VPI_ASSERT_NXT(a_integ_max, state == vpi_pkg::ST_INTEG, integ <= $past(int_max), "integrator above upper bound")
  // With ordered bounds the integrator never drops below the lower bound.
  `VPI_ASSERT_NXT(a_integ_min, (state == vpi_pkg::ST_INTEG) && (int_min <= int_max), integ >= $past(int_min), "integrator below lower bound")

endmodule

// ===== sim/tb_top.sv =====
module tb_top;
  import vpi_pkg::*;

  // Expected torque result of one control tick.
  typedef struct packed {
    logic signed [DATA_W-1:0] torque;
    logic                     finished;
  } torque_result_t;

  // One row of the directed stimulus. Rows with has_typed set carry their
  // expected result; the others are checked against the predictor.
  typedef struct packed {
    logic [1:0]        req;
    logic [DATA_W-1:0] val;
    logic              has_typed;
    logic [DATA_W-1:0] typed_torque;
    logic              typed_finished;
  } stim_row_t;

  localparam int DIRECTED_ROWS = 24;
  localparam int SETTLE_CYCLES = 20;

  logic                     clk;
  logic                     rst;
  logic                     cfg_valid;
  logic                     cfg_ready;
  logic [CFG_IDX_W-1:0]     cfg_index;
  logic [DATA_W-1:0]        cfg_data;
  logic                     in_valid;
  logic                     in_ready;
  logic [1:0]               req_type;
  logic signed [DATA_W-1:0] value;
  logic                     out_valid;
  logic                     out_ready;
  logic signed [DATA_W-1:0] torque;
  logic                     halted;

  // Register copies kept by the predictor.
  longint r_damping, r_int_gain, r_int_max, r_int_min, r_coeff;
  // Regulator state kept by the predictor.
  longint m_target, m_ftarget, m_fdamp, m_integ;
  logic   m_finished;

  torque_result_t pending_torques[$];
  int mismatch_count = 0;
  int in_idle_pct = 38;
  int out_idle_pct = 38;
  int hold_request = 0;

  stim_row_t directed_rows [DIRECTED_ROWS] = '{
    '{REQ_TICK,  32'sd0,          1'b1, 32'sd0,          1'b0},
    '{REQ_TICK,  -32'sd65536,     1'b1, 32'sd3440640,    1'b0},
    '{REQ_STOP,  32'sd0,          1'b0, 32'sd0,          1'b0},
    '{REQ_TICK,  32'sd0,          1'b1, 32'sd163840,     1'b1},
    '{REQ_TICK,  32'h8000_0000,   1'b1, 32'h7FFF_FFFF,   1'b1},
    '{REQ_TICK,  32'h7FFF_FFFF,   1'b1, 32'h8000_0000,   1'b1},
    '{REQ_START, 32'sd0,          1'b0, 32'sd0,          1'b0},
    '{REQ_SET,   32'h7FFF_FFFF,   1'b0, 32'sd0,          1'b0},
    '{REQ_TICK,  32'h8000_0000,   1'b1, 32'h7FFF_FFFF,   1'b0},
    '{REQ_SET,   32'h8000_0000,   1'b0, 32'sd0,          1'b0},
    '{REQ_TICK,  32'h7FFF_FFFF,   1'b1, 32'h8000_0000,   1'b0},
    '{REQ_SET,   32'sd65536,      1'b0, 32'sd0,          1'b0},
    '{REQ_TICK,  32'sd0,          1'b0, 32'sd0,          1'b0},
    '{REQ_TICK,  32'sd65536,      1'b0, 32'sd0,          1'b0},
    '{REQ_SET,   -32'sd131072,    1'b0, 32'sd0,          1'b0},
    '{REQ_STOP,  32'hFFFF_FFFF,   1'b0, 32'sd0,          1'b0},
    '{REQ_TICK,  32'sd12345,      1'b0, 32'sd0,          1'b0},
    '{REQ_START, 32'h5555_AAAA,   1'b0, 32'sd0,          1'b0},
    '{REQ_TICK,  -32'sd1,         1'b0, 32'sd0,          1'b0},
    '{REQ_SET,   32'sd1000,       1'b0, 32'sd0,          1'b0},
    '{REQ_TICK,  32'sd999,        1'b0, 32'sd0,          1'b0},
    '{REQ_TICK,  32'sh0000_8000,  1'b0, 32'sd0,          1'b0},
    '{REQ_STOP,  32'sd0,          1'b0, 32'sd0,          1'b0},
    '{REQ_TICK,  32'sd0,          1'b0, 32'sd0,          1'b0}
  };

  velocity_pi_with_filtered_setpoint u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .req_type  (req_type),
    .value     (value),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .torque    (torque),
    .halted    (halted)
  );

  // 10 time unit clock.
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Moving average step toward a goal, with the coefficient capped at one.
  function automatic longint ema_step(longint prev, longint goal);
    longint c;
    longint acc;
    c = r_coeff;
    if (c > (64'sd1 <<< COEFF_BITS)) c = 64'sd1 <<< COEFF_BITS;
    acc = c * goal + ((64'sd1 <<< COEFF_BITS) - c) * prev + (64'sd1 <<< (COEFF_BITS - 1));
    return acc >>> COEFF_BITS;
  endfunction

  // Updates the regulator state for one request and forms the tick's torque.
  task automatic predict_request(input logic [1:0] rq, input logic signed [DATA_W-1:0] v,
                                 output bit produces, output torque_result_t res);
    longint meas;
    longint err;
    longint acc;
    longint tq;
    produces = 1'b0;
    res = '0;
    meas = longint'(v);
    case (rq)
      REQ_SET: begin
        m_target = meas;
      end
      REQ_START: begin
        m_finished = 1'b0;
        m_target = 0;
        m_ftarget = 0;
      end
      REQ_STOP: begin
        m_finished = 1'b1;
      end
      default: begin
        m_ftarget = ema_step(m_ftarget, m_target);
        m_fdamp = ema_step(m_fdamp, r_damping);
        err = m_ftarget - meas;
        acc = m_integ + err;
        // The lower bound goes first, so crossed bounds end at the upper one.
        if (acc < r_int_min) acc = r_int_min;
        if (acc > r_int_max) acc = r_int_max;
        m_integ = acc;
        tq = m_fdamp * err + r_int_gain * m_integ;
        tq = (tq + (64'sd1 <<< (FRAC_BITS_DEF - 1))) >>> FRAC_BITS_DEF;
        if (tq > 64'sd2147483647) tq = 64'sd2147483647;
        if (tq < -64'sd2147483648) tq = -64'sd2147483648;
        res.torque = tq[DATA_W-1:0];
        res.finished = m_finished;
        produces = 1'b1;
      end
    endcase
  endtask

  // Writes one register over the configuration channel and mirrors it.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_DAMPING:  r_damping  = longint'(data[GAIN_W-1:0]);
      REG_INT_GAIN: r_int_gain = longint'(data[GAIN_W-1:0]);
      REG_INT_MAX:  r_int_max  = longint'($signed(data));
      REG_INT_MIN:  r_int_min  = longint'($signed(data));
      REG_COEFF:    r_coeff    = longint'(data[COEFF_W-1:0]);
      default: ;
    endcase
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Offers one request, waits for its transfer and records what it should yield.
  task automatic issue_request(input logic [1:0] rq, input logic [DATA_W-1:0] v,
                               input logic has_typed, input torque_result_t typed);
    bit produces;
    torque_result_t predicted;
    while ($urandom_range(0, 99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    req_type <= rq;
    value    <= v;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_request(rq, v, produces, predicted);
    if (produces) pending_torques.push_back(has_typed ? typed : predicted);
  endtask

  // Lets every expected result arrive, then allows the block to settle.
  task automatic drain_requests();
    in_valid <= 1'b0;
    while (pending_torques.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [DATA_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2, 3, 4, 5: return 32'($urandom_range(0, 524288)) - 32'd262144;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [DATA_W-1:0] pick_gain();
    return ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 32'h00A0_0000);
  endfunction

  function automatic logic [DATA_W-1:0] pick_bound(input bit upper);
    if ($urandom_range(0, 4) == 0) return $urandom;
    if (upper) return $urandom_range(0, 32'h0010_0000);
    return 32'(-int'($urandom_range(0, 32'h0010_0000)));
  endfunction

  // Register settings of each random phase: extremes in phases 1 and 2, crossed bounds in 3, random ones otherwise.
  task automatic program_phase(input int ph);
    case (ph)
      1: begin
        write_reg(REG_DAMPING,  32'hFFFF_FFFF);
        write_reg(REG_INT_GAIN, 32'hFFFF_FFFF);
        write_reg(REG_INT_MAX,  32'h7FFF_FFFF);
        write_reg(REG_INT_MIN,  32'h8000_0000);
        write_reg(REG_COEFF,    32'hFFFF_FFFF);
      end
      2: begin
        write_reg(REG_DAMPING,  32'd0);
        write_reg(REG_INT_GAIN, 32'd0);
        write_reg(REG_INT_MAX,  32'd0);
        write_reg(REG_INT_MIN,  32'd0);
        write_reg(REG_COEFF,    32'd0);
      end
      3: begin
        // Crossed clamp bounds.
        write_reg(REG_DAMPING,  pick_gain());
        write_reg(REG_INT_GAIN, pick_gain());
        write_reg(REG_INT_MAX,  32'(-int'($urandom_range(0, 65536))));
        write_reg(REG_INT_MIN,  $urandom_range(1, 65536));
        write_reg(REG_COEFF,    $urandom_range(0, 32'h1FFFF));
      end
      default: begin
        write_reg(REG_DAMPING,  pick_gain());
        write_reg(REG_INT_GAIN, pick_gain());
        write_reg(REG_INT_MAX,  pick_bound(1'b1));
        write_reg(REG_INT_MIN,  pick_bound(1'b0));
        write_reg(REG_COEFF,    ($urandom_range(0, 3) == 0) ? $urandom
                                                            : $urandom_range(0, 32'h10000));
        // Indexes past the last register must leave everything unchanged.
        write_reg(CFG_IDX_W'($urandom_range(5, 7)), $urandom);
      end
    endcase
  endtask

  // Result side: random back-pressure, a long hold-off on request, and checking.
  initial begin
    int hold_left;
    torque_result_t exp_res;
    hold_left = 0;
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) begin
        if (pending_torques.size() == 0) begin
          $error("unexpected result transfer: torque %0d halted %0b",
                 torque, halted);
          mismatch_count++;
        end else begin
          exp_res = pending_torques.pop_front();
          if (torque !== exp_res.torque) begin
            $error("torque: expected %0d, actual %0d", exp_res.torque, torque);
            mismatch_count++;
          end
          if (halted !== exp_res.finished) begin
            $error("halted: expected %0b, actual %0b",
                   exp_res.finished, halted);
            mismatch_count++;
          end
        end
      end
      if (hold_request > 0) begin
        hold_left = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= out_idle_pct);
      end
    end
  end

  // Stimulus: directed table, then random phases under several register settings.
  initial begin
    torque_result_t typed;
    int k;
    logic [1:0] rq;
    rst       = 1'b1;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    in_valid  = 1'b0;
    req_type  = REQ_TICK;
    value     = '0;
    r_damping  = 50 * (64'sd1 <<< FRAC_BITS_DEF);
    r_int_gain = 5 * (64'sd1 <<< FRAC_BITS_DEF);
    r_int_max  = 64'sd1 <<< (FRAC_BITS_DEF - 1);
    r_int_min  = -(64'sd1 <<< (FRAC_BITS_DEF - 1));
    r_coeff    = 64'sd1 <<< COEFF_BITS;
    m_target   = 0;
    m_ftarget  = 0;
    m_fdamp    = r_damping;
    m_integ    = 0;
    m_finished = 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < DIRECTED_ROWS; i++) begin
      typed.torque = directed_rows[i].typed_torque;
      typed.finished = directed_rows[i].typed_finished;
      issue_request(directed_rows[i].req, directed_rows[i].val,
                    directed_rows[i].has_typed, typed);
    end
    drain_requests();

    for (int ph = 0; ph < 8; ph++) begin
      program_phase(ph);
      in_idle_pct  = (ph == 5) ? 0 : 38;
      out_idle_pct = (ph == 5) ? 0 : 38;
      // Hold the result side off long enough for the input to stall.
      if (ph == 4) hold_request = 400;
      for (int n = 0; n < 62; n++) begin
        k = $urandom_range(0, 99);
        if (k < 60) rq = REQ_TICK;
        else if (k < 78) rq = REQ_SET;
        else if (k < 89) rq = REQ_START;
        else rq = REQ_STOP;
        issue_request(rq, pick_value(), 1'b0, '0);
      end
      drain_requests();
    end

    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #2000000;
    $display("Test completed with failures");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+hdl
hdl/vpi_pkg.sv
hdl/velocity_pi_with_filtered_setpoint.sv
sim/tb_top.sv
